// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; empty bodies when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: src/tdsq_pkg.sv
// ----------------------------------------------------------------------------
// Timer queue package
// Entry layout, cell controls and result codes of the sorted timer queue.
// ----------------------------------------------------------------------------
package tdsq_pkg;

  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int MAX_RESULTS     = 16;
  localparam int FIRE_W          = $clog2(MAX_RESULTS);
  localparam int SEC_W           = 32;
  localparam int TAG_W           = 8;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_ENQ  = 1'b1;

  typedef enum logic [1:0] {
    KIND_ACCEPT = 2'd0,
    KIND_FULL   = 2'd1,
    KIND_FIRED  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [SEC_W-1:0] dl;
    logic [SEC_W-1:0] reg_at;
    logic [SEC_W-1:0] dur;
    logic [TAG_W-1:0] tag;
  } entry_t;

  typedef struct packed {
    logic ins;
    logic pop;
  } cell_op_t;

endpackage

// File: src/tdsq_cell.sv
// ----------------------------------------------------------------------------
// Timer queue cell
// One slot of the sorted chain: holds, takes the new entry, or shifts.
// ----------------------------------------------------------------------------
module tdsq_cell (
  input  logic              clk,
  input  tdsq_pkg::cell_op_t op,
  input  logic              occ,
  input  logic              left_keep,
  input  tdsq_pkg::entry_t  new_ent,
  input  tdsq_pkg::entry_t  left_ent,
  input  tdsq_pkg::entry_t  right_ent,
  output tdsq_pkg::entry_t  ent,
  output logic              keep
);
  import tdsq_pkg::*;

  entry_t ent_r;
  entry_t ent_nxt;

  // stay in place when this slot is due no later than the new entry
  assign keep = occ && (ent_r.dl <= new_ent.dl);
  assign ent  = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    if (op.ins) begin
      if (!keep) begin
        ent_nxt = left_keep ? new_ent : left_ent;
      end
    end else if (op.pop) begin
      ent_nxt = right_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

// File: src/deadline_sorted_timer_queue.sv
// ----------------------------------------------------------------------------
// Deadline sorted timer queue
// Timeouts held in a chain of cells sorted by deadline; ticks fire due heads.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                              | tuser   | tlast
//  in_     | in  | wait_seconds, event_tag            | command | -
//  out_    | out | fired_tag, registered_at,          | kind    | last_result
//          |     | duration_out, fired_at             |         |
//
// Enqueue: accepted in ST_IDLE, inserted into the chain in ST_INS when out_free.
// Tick: accepted in ST_IDLE, then ST_FIRE pops one fired entry at a time while out_free,
// since the head cell holds the only readable entry and the whole chain shifts by one slot.
// One item is in work at a time; a stalled result register holds the sequencer.
// Reset clears the second counter and the entry count; cells need no clearing.
module deadline_sorted_timer_queue #(
  parameter int QUEUE_DEPTH = tdsq_pkg::DEF_QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [39:0]  in_tdata,   // wait_seconds[31:0], event_tag[39:32]
  input  logic         in_tuser,   // command
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,  // fired_tag[7:0], registered_at[39:8],
                                   // duration_out[71:40], fired_at[103:72]
  output logic [1:0]   out_tuser,  // kind
  output logic         out_tlast
);
  import tdsq_pkg::*;

  `include "assert_macros.svh"

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_INS  = 3'b010,
    ST_FIRE = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [SEC_W-1:0]  now_r, now_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [FIRE_W-1:0] fire_n_r, fire_n_nxt;
  entry_t            new_r, new_nxt;

  logic              out_valid_r, out_valid_nxt;
  kind_t             out_kind_r;
  entry_t            out_ent_r;
  logic [SEC_W-1:0]  out_at_r;
  logic              out_last_r;

  logic              out_load;
  kind_t             load_kind;
  entry_t            load_ent;
  logic              load_last;

  cell_op_t          op;
  entry_t            cell_ent  [QUEUE_DEPTH];
  logic              cell_keep [QUEUE_DEPTH];

  logic              in_acc;
  logic              out_free;
  logic              full;
  logic              head_due;
  logic              next_due;
  logic [SEC_W:0]    dl_sum;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign full       = (count_r == CNT_W'(QUEUE_DEPTH));
  assign dl_sum     = {1'b0, now_r} + {1'b0, in_tdata[31:0]};
  assign head_due   = (count_r != '0) && (cell_ent[0].dl <= now_r);
  assign next_due   = (count_r > CNT_W'(1)) && (cell_ent[1].dl <= now_r) &&
                      (fire_n_r != FIRE_W'(MAX_RESULTS - 1));

  genvar gi;
  generate
    for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
      logic   occ;
      logic   lkeep;
      entry_t lent;
      entry_t rent;
      assign occ = (CNT_W'(gi) < count_r);
      if (gi == 0) begin : g_first
        assign lkeep = 1'b1;
        assign lent  = new_r;
      end else begin : g_mid
        assign lkeep = cell_keep[gi-1];
        assign lent  = cell_ent[gi-1];
      end
      if (gi == QUEUE_DEPTH - 1) begin : g_last
        assign rent = cell_ent[gi];
      end else begin : g_inner
        assign rent = cell_ent[gi+1];
      end
      tdsq_cell u_cell (
        .clk       (clk),
        .op        (op),
        .occ       (occ),
        .left_keep (lkeep),
        .new_ent   (new_r),
        .left_ent  (lent),
        .right_ent (rent),
        .ent       (cell_ent[gi]),
        .keep      (cell_keep[gi])
      );
    end
  endgenerate

  always_comb begin
    state_nxt  = state_r;
    now_nxt    = now_r;
    count_nxt  = count_r;
    fire_n_nxt = fire_n_r;
    new_nxt    = new_r;
    op         = '0;
    out_load   = 1'b0;
    load_kind  = KIND_ACCEPT;
    load_ent   = new_r;
    load_last  = 1'b1;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          fire_n_nxt = '0;
          if (in_tuser == CMD_ENQ) begin
            // saturate the deadline at the top of the second range
            new_nxt.dl     = dl_sum[SEC_W] ? '1 : dl_sum[SEC_W-1:0];
            new_nxt.reg_at = now_r;
            new_nxt.dur    = in_tdata[31:0];
            new_nxt.tag    = in_tdata[39:32];
            state_nxt      = ST_INS;
          end else begin
            now_nxt   = (now_r == '1) ? now_r : now_r + 1'b1;
            state_nxt = ST_FIRE;
          end
        end
      end
      ST_INS: begin
        if (out_free) begin
          out_load  = 1'b1;
          load_kind = full ? KIND_FULL : KIND_ACCEPT;
          if (!full) begin
            op.ins    = 1'b1;
            count_nxt = count_r + 1'b1;
          end
          state_nxt = ST_IDLE;
        end
      end
      ST_FIRE: begin
        if (!head_due) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_load   = 1'b1;
          load_kind  = KIND_FIRED;
          load_ent   = cell_ent[0];
          load_last  = !next_due;
          op.pop     = 1'b1;
          count_nxt  = count_r - 1'b1;
          fire_n_nxt = fire_n_r + 1'b1;
          if (!next_due) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      now_r       <= '0;
      count_r     <= '0;
      fire_n_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      now_r       <= now_nxt;
      count_r     <= count_nxt;
      fire_n_r    <= fire_n_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    new_r <= new_nxt;
    if (out_load) begin
      out_kind_r <= load_kind;
      out_ent_r  <= load_ent;
      out_at_r   <= now_r;
      out_last_r <= load_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_at_r, out_ent_r.dur, out_ent_r.reg_at, out_ent_r.tag};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  `ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_r <= CNT_W'(QUEUE_DEPTH), "count overflow")
  `ASSERT_IMPLY(a_head_sorted, clk, rst_n, count_r >= CNT_W'(2), cell_ent[0].dl <= cell_ent[1].dl, "head out of order")
  `ASSERT_NEXT(a_insert_count, clk, rst_n, (state_r == ST_INS) && out_load && !full, count_r == $past(count_r) + 1'b1, "insert lost")
  `ASSERT_NEXT(a_tick_advance, clk, rst_n, in_acc && (in_tuser == CMD_TICK), (now_r == $past(now_r) + 1'b1) || ($past(now_r) == '1), "tick did not advance")

endmodule

// File: verif/tb_deadline_sorted_timer_queue.sv
// ----------------------------------------------------------------------------
// Deadline sorted timer queue testbench
// Drives enqueue and tick items into the timer queue under random stalls on
// both streams. A behavioral sorted table predicts accepted, full and fired
// results of untyped items; a scoreboard checks all field by field in order.
// ----------------------------------------------------------------------------
module tb_deadline_sorted_timer_queue;
  import tdsq_pkg::*;

  localparam int               QUEUE_DEPTH    = DEF_QUEUE_DEPTH;
  localparam logic [SEC_W-1:0] SEC_MAX        = '1;
  localparam int               RAND_ITEMS     = 445;
  localparam int               QUIET_ITEMS    = 60;
  localparam int               DRAIN_EVERY    = 120;
  localparam int               WATCHDOG_LIMIT = 1000;
  localparam int               TAIL_CYCLES    = 40;

  typedef struct {
    kind_t            kind;
    logic [TAG_W-1:0] tag;
    logic [SEC_W-1:0] reg_at;
    logic [SEC_W-1:0] dur;
    logic [SEC_W-1:0] at;
    logic             is_last;
  } timer_result_t;

  typedef struct {
    logic             cmd;
    logic [SEC_W-1:0] secs;
    logic [TAG_W-1:0] tag;
    logic             typed;
    kind_t            kind;
    logic [SEC_W-1:0] at;
  } stim_row_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [39:0]  in_tdata = '0;   // wait_seconds[31:0], event_tag[39:32]
  logic         in_tuser = 1'b0; // command
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [103:0] out_tdata;       // fired_tag[7:0], registered_at[39:8],
                                 // duration_out[71:40], fired_at[103:72]
  logic [1:0]   out_tuser;       // kind
  logic         out_tlast;

  deadline_sorted_timer_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the timer table
  logic [SEC_W-1:0] shadow_now = '0;
  int               shadow_count = 0;
  entry_t           shadow_ent [QUEUE_DEPTH];

  timer_result_t    step_results [$];
  timer_result_t    due_results [$];
  stim_row_t        dir_rows [$];

  // Item currently offered; typed rows carry their own expected result
  logic             cur_typed = 1'b0;
  kind_t            cur_kind = KIND_ACCEPT;
  logic [SEC_W-1:0] cur_at = '0;

  logic in_took = 1'b0;
  logic quiet = 1'b0;
  int   err_count = 0;
  int   stall_cycles = 0;
  int   n_enq = 0, n_tick = 0, n_results = 0, n_fired = 0, n_full = 0;
  int   peak_depth = 0, peak_burst = 0;
  int   rx_left = 0;
  logic rx_stall = 1'b0;

  function automatic void push_result(kind_t kind, logic [TAG_W-1:0] tag,
                                      logic [SEC_W-1:0] reg_at,
                                      logic [SEC_W-1:0] dur, logic is_last);
    timer_result_t r;
    r.kind    = kind;
    r.tag     = tag;
    r.reg_at  = reg_at;
    r.dur     = dur;
    r.at      = shadow_now;
    r.is_last = is_last;
    step_results.push_back(r);
  endfunction

  // Apply one item to the shadow table and collect the results it causes
  function automatic void timer_queue_step(logic cmd, logic [SEC_W-1:0] secs,
                                           logic [TAG_W-1:0] tag);
    entry_t e;
    int     pos;
    int     n;
    if (cmd == CMD_ENQ) begin
      if (shadow_count >= QUEUE_DEPTH) begin
        push_result(KIND_FULL, tag, shadow_now, secs, 1'b1);
      end else begin
        e.dl     = (secs > SEC_MAX - shadow_now) ? SEC_MAX : shadow_now + secs;
        e.reg_at = shadow_now;
        e.dur    = secs;
        e.tag    = tag;
        // equal deadlines keep arrival order
        pos = 0;
        while (pos < shadow_count && shadow_ent[pos].dl <= e.dl) pos++;
        for (int i = shadow_count; i > pos; i--) shadow_ent[i] = shadow_ent[i-1];
        shadow_ent[pos] = e;
        shadow_count++;
        push_result(KIND_ACCEPT, tag, shadow_now, secs, 1'b1);
      end
    end else begin
      if (shadow_now != SEC_MAX) shadow_now++;
      n = 0;
      while (n < shadow_count && n < MAX_RESULTS && shadow_ent[n].dl <= shadow_now) n++;
      for (int i = 0; i < n; i++) begin
        push_result(KIND_FIRED, shadow_ent[i].tag, shadow_ent[i].reg_at,
                    shadow_ent[i].dur, i == n - 1);
      end
      for (int i = n; i < shadow_count; i++) shadow_ent[i-n] = shadow_ent[i];
      shadow_count -= n;
    end
  endfunction

  function automatic void check_field(string name, logic [SEC_W-1:0] want,
                                      logic [SEC_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      err_count++;
    end
  endfunction

  // Sample both streams at the rising edge
  always @(posedge clk) begin
    timer_result_t exp_r;
    in_took = 1'b0;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        stall_cycles = 0;
        n_results++;
        if (due_results.size() == 0) begin
          $error("result with no expectation waiting: kind %0d tag %0h",
                 out_tuser, out_tdata[7:0]);
          err_count++;
        end else begin
          exp_r = due_results.pop_front();
          check_field("kind", SEC_W'(exp_r.kind), SEC_W'(out_tuser));
          check_field("fired_tag", SEC_W'(exp_r.tag), SEC_W'(out_tdata[7:0]));
          check_field("registered_at", exp_r.reg_at, out_tdata[39:8]);
          check_field("duration_out", exp_r.dur, out_tdata[71:40]);
          check_field("fired_at", exp_r.at, out_tdata[103:72]);
          check_field("last_result", SEC_W'(exp_r.is_last), SEC_W'(out_tlast));
        end
      end
      if (in_tvalid && in_tready) begin
        in_took = 1'b1;
        stall_cycles = 0;
        timer_queue_step(in_tuser, in_tdata[31:0], in_tdata[39:32]);
        if (in_tuser == CMD_ENQ) begin
          n_enq++;
          if (step_results[0].kind == KIND_FULL) n_full++;
        end else begin
          n_tick++;
          n_fired += step_results.size();
          if (step_results.size() > peak_burst) peak_burst = step_results.size();
        end
        if (shadow_count > peak_depth) peak_depth = shadow_count;
        if (cur_typed) begin
          exp_r.kind    = cur_kind;
          exp_r.tag     = in_tdata[39:32];
          exp_r.reg_at  = cur_at;
          exp_r.dur     = in_tdata[31:0];
          exp_r.at      = cur_at;
          exp_r.is_last = 1'b1;
          due_results.push_back(exp_r);
        end else begin
          foreach (step_results[i]) due_results.push_back(step_results[i]);
        end
        step_results.delete();
      end
      if (!in_took && !(out_tvalid && out_tready)) begin
        stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
          $display("tb_deadline_sorted_timer_queue: done, errors");
          $finish;
        end
      end
    end
  end

  // Result side: alternate ready runs and stall bursts
  always @(negedge clk) begin
    if (quiet || !rst_n) begin
      out_tready <= 1'b1;
    end else begin
      if (rx_left == 0) begin
        // never chain two stall bursts
        rx_stall = !rx_stall && ($urandom_range(0, 9) < 4);
        if (rx_stall) rx_left = $urandom_range(1, 19);
        else if ($urandom_range(0, 7) == 0) rx_left = $urandom_range(30, 80);
        else rx_left = $urandom_range(1, 8);
      end
      rx_left--;
      out_tready <= !rx_stall;
    end
  end

  function automatic void add_row(logic cmd, logic [SEC_W-1:0] secs,
                                  logic [TAG_W-1:0] tag, logic typed,
                                  kind_t kind, logic [SEC_W-1:0] at);
    stim_row_t r;
    r.cmd   = cmd;
    r.secs  = secs;
    r.tag   = tag;
    r.typed = typed;
    r.kind  = kind;
    r.at    = at;
    dir_rows.push_back(r);
  endfunction

  // Offer one item at a falling edge and hold it until accepted
  task automatic send_item(logic cmd, logic [SEC_W-1:0] secs, logic [TAG_W-1:0] tag,
                           logic typed, kind_t kind, logic [SEC_W-1:0] at);
    cur_typed = typed;
    cur_kind  = kind;
    cur_at    = at;
    in_tuser  <= cmd;
    in_tdata  <= {tag, secs};
    in_tvalid <= 1'b1;
    do @(negedge clk); while (!in_took);
  endtask

  task automatic sender_idle();
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (due_results.size() != 0);
  endtask

  initial begin
    logic             cmd;
    logic [SEC_W-1:0] secs;
    int               enq_pct;
    int               sel;
    int               wide_left;

    wide_left = 4;
    enq_pct = 50;

    add_row(CMD_TICK, 32'd0, 8'h00, 1'b0, KIND_ACCEPT, 32'd0);
    add_row(CMD_ENQ, 32'd0, 8'h00, 1'b1, KIND_ACCEPT, 32'd1);
    add_row(CMD_TICK, 32'd0, 8'h00, 1'b0, KIND_ACCEPT, 32'd0);
    // fill the table; zero waits sort ahead of the one-second waits
    for (int i = 0; i < QUEUE_DEPTH; i++)
      add_row(CMD_ENQ, SEC_W'(i % 2 == 0), TAG_W'(8'h10 + i), 1'b1, KIND_ACCEPT,
              32'd2);
    add_row(CMD_ENQ, 32'h1234_5678, 8'hA5, 1'b1, KIND_FULL, 32'd2);
    add_row(CMD_TICK, 32'd0, 8'h00, 1'b0, KIND_ACCEPT, 32'd0);
    // saturated deadlines, then a head insert in front of them
    add_row(CMD_ENQ, 32'hFFFF_FFFF, 8'hFF, 1'b1, KIND_ACCEPT, 32'd3);
    add_row(CMD_ENQ, 32'hFFFF_FFFE, 8'h80, 1'b1, KIND_ACCEPT, 32'd3);
    add_row(CMD_ENQ, 32'd5, 8'h7F, 1'b1, KIND_ACCEPT, 32'd3);
    add_row(CMD_TICK, 32'd0, 8'h00, 1'b0, KIND_ACCEPT, 32'd0);

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      sender_idle();
      send_item(dir_rows[i].cmd, dir_rows[i].secs, dir_rows[i].tag,
                dir_rows[i].typed, dir_rows[i].kind, dir_rows[i].at);
    end
    drain_results();

    for (int k = 0; k < RAND_ITEMS; k++) begin
      if (k % 40 == 0) enq_pct = 30 + 20 * $urandom_range(0, 2);
      if (k == RAND_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      if (k > 0 && k % DRAIN_EVERY == 0) drain_results();
      else sender_idle();
      cmd = ($urandom_range(0, 99) < enq_pct) ? CMD_ENQ : CMD_TICK;
      sel = $urandom_range(0, 99);
      // keep long waits rare: they hold a slot for the rest of the run
      if (sel < 80) secs = $urandom_range(0, 12);
      else if (sel < 96) secs = $urandom_range(13, 80);
      else if (wide_left > 0 && cmd == CMD_ENQ) begin
        secs = $urandom;
        wide_left--;
      end else secs = $urandom_range(0, 3);
      send_item(cmd, secs, TAG_W'($urandom_range(0, 255)), 1'b0, KIND_ACCEPT, '0);
    end

    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("covered %0d enqueues (%0d full) and %0d ticks, %0d results, %0d fired",
             n_enq, n_full, n_tick, n_results, n_fired);
    $display("peak table depth %0d, largest firing burst %0d", peak_depth, peak_burst);
    if (err_count == 0 && due_results.size() == 0) begin
      $display("tb_deadline_sorted_timer_queue: done, clean");
    end else begin
      $display("tb_deadline_sorted_timer_queue: done, errors");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+src
src/tdsq_pkg.sv
src/tdsq_cell.sv
src/deadline_sorted_timer_queue.sv
verif/tb_deadline_sorted_timer_queue.sv
